[rtl/core/ahpf_pkg.sv]
`default_nettype none

package ahpf_pkg;

  localparam int unsigned NUM_AXES     = 3;
  localparam int unsigned DT_W         = 24;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned STATE_W      = 18;
  localparam int unsigned ALPHA_W      = 17;
  localparam int unsigned DEN_W        = 25;
  localparam int unsigned RC_W         = 24;
  localparam int unsigned GAIN_W       = 8;
  localparam int unsigned WARM_W       = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned IN_DATA_W    = 72;
  localparam int unsigned OUT_DATA_W   = 48;
  localparam int unsigned AXIS_W       = 2;

  // one quotient bit per step, quotient is at most 1.0 in q1.16
  localparam int unsigned DIV_STEPS    = 17;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [DT_W-1:0]    MAX_STEP_US = 24'd1000000;
  localparam logic [ALPHA_W-1:0] ONE_Q16     = 17'h10000;
  localparam logic [RC_W-1:0]    RC_RESET    = 24'd3000000;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd20;
  localparam logic [WARM_W-1:0]  WARM_RESET  = 8'd100;

  localparam logic [CFG_IDX_W-1:0] REG_RC_US        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_MUL,
    ST_HP,
    ST_BOOST,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              load;
    logic              raw;
    logic              first;
    logic              div_init;
    logic              div_step;
    logic              mul;
    logic              hp;
    logic              boost;
    logic              commit;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic long_step;
    logic first;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/accel_highpass_filter_core.sv]
`default_nettype none

// three-axis first-order rc high-pass filter for accelerometer samples. each
// input transaction carries one sample and the time step since the last one;
// each yields exactly one result transaction. a step over one second returns
// the raw sample with passed_through set and leaves the filter state alone;
// the first sample after reset is echoed and seeds the filter. later samples
// compute alpha = rc/(rc+dt) in q1.16 on a serial restoring divider (one
// quotient bit per step) and then run the three axes one after the other
// through a shared multiply, round/saturate and boost step. one sample is
// in flight at a time, and a new sample is taken while the previous result
// still waits in the output register. configuration must be written only
// while idle; the block itself does not enforce it.
module accel_highpass_filter_core #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // dt_us[23:0], accel_x[39:24], accel_y[55:40], accel_z[71:56]
  input  wire logic [ahpf_pkg::IN_DATA_W-1:0]      in_tdata,

  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // out_x[15:0], out_y[31:16], out_z[47:32]
  output logic      [ahpf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // passed_through[0]
  output logic                                     out_tuser,

  // register 0 rc_us, 1 boost_gain, 2 warmup_count
  input  wire logic                                cfg_we,
  input  wire logic [ahpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ahpf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // command and status between sequencer and datapath
  ahpf_pkg::cmd_t    cmd;
  ahpf_pkg::status_t status;

  ahpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ahpf_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

[rtl/core/ahpf_div.sv]
`default_nettype none

// restoring divider for alpha = rc * 2^16 / (rc + dt), one quotient bit per step
module ahpf_div (
  input  wire logic                          clk,
  input  wire logic                          init,
  input  wire logic                          step,
  input  wire logic [ahpf_pkg::RC_W-1:0]     rc,
  input  wire logic [ahpf_pkg::DT_W-1:0]     dt,
  output logic      [ahpf_pkg::ALPHA_W-1:0]  alpha
);

  logic [ahpf_pkg::DEN_W-1:0]   den_r;
  logic [ahpf_pkg::DEN_W-1:0]   rem_r;
  logic [ahpf_pkg::ALPHA_W-1:0] quo_r;
  logic                         nb_r;
  logic                         zero_r;

  logic [ahpf_pkg::DEN_W:0] trial;
  logic                     ge;

  always_comb begin
    trial = {rem_r, nb_r};
    ge    = trial >= {1'b0, den_r};
  end

  // quotient bits above bit 16 are zero since rc <= rc + dt, so the
  // remainder starts at rc * 2^16 >> 17
  always_ff @(posedge clk) begin
    if (init) begin
      den_r  <= ahpf_pkg::DEN_W'(rc) + ahpf_pkg::DEN_W'(dt);
      rem_r  <= ahpf_pkg::DEN_W'(rc[ahpf_pkg::RC_W-1:1]);
      nb_r   <= rc[0];
      quo_r  <= '0;
      zero_r <= (rc == '0) && (dt == '0);
    end else if (step) begin
      rem_r <= ge ? ahpf_pkg::DEN_W'(trial - {1'b0, den_r}) : ahpf_pkg::DEN_W'(trial);
      nb_r  <= 1'b0;
      quo_r <= {quo_r[ahpf_pkg::ALPHA_W-2:0], ge};
    end
  end

  assign alpha = zero_r ? ahpf_pkg::ONE_Q16 : quo_r;

endmodule

`default_nettype wire

[rtl/core/ahpf_datapath.sv]
`default_nettype none

module ahpf_datapath #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ahpf_pkg::cmd_t                    cmd,
  output ahpf_pkg::status_t                      status,
  input  wire logic [ahpf_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [ahpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ahpf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic      [ahpf_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                   out_tuser
);

  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);

  // configuration
  logic [ahpf_pkg::RC_W-1:0]   rc_r;
  logic [ahpf_pkg::GAIN_W-1:0] gain_r;
  logic [ahpf_pkg::WARM_W-1:0] warm_r;

  // captured sample
  logic        [ahpf_pkg::DT_W-1:0]     dt_r;
  logic signed [ahpf_pkg::SAMPLE_W-1:0] x_r [ahpf_pkg::NUM_AXES];

  // filter history
  logic signed [ahpf_pkg::SAMPLE_W-1:0] last_in_r  [ahpf_pkg::NUM_AXES];
  logic signed [ahpf_pkg::STATE_W-1:0]  last_out_r [ahpf_pkg::NUM_AXES];
  logic        [CNT_W-1:0]              held_r;

  // per-axis work registers and result
  logic signed [37:0]                   prod_r;
  logic signed [ahpf_pkg::SAMPLE_W-1:0] res_r [ahpf_pkg::NUM_AXES];
  logic                                 pass_r;

  logic [ahpf_pkg::ALPHA_W-1:0] alpha;

  ahpf_div u_div (
    .clk   (clk),
    .init  (cmd.div_init),
    .step  (cmd.div_step),
    .rc    (rc_r),
    .dt    (dt_r),
    .alpha (alpha)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r   <= ahpf_pkg::RC_RESET;
      gain_r <= ahpf_pkg::GAIN_RESET;
      warm_r <= ahpf_pkg::WARM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ahpf_pkg::REG_RC_US:        rc_r   <= cfg_wdata;
        ahpf_pkg::REG_BOOST_GAIN:   gain_r <= cfg_wdata[ahpf_pkg::GAIN_W-1:0];
        ahpf_pkg::REG_WARMUP_COUNT: warm_r <= cfg_wdata[ahpf_pkg::WARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r   <= in_tdata[23:0];
      x_r[0] <= in_tdata[39:24];
      x_r[1] <= in_tdata[55:40];
      x_r[2] <= in_tdata[71:56];
    end
  end

  always_comb begin
    status.long_step = dt_r > ahpf_pkg::MAX_STEP_US;
    status.first     = held_r == '0;
  end

  // difference and multiply by alpha
  logic signed [19:0] diff;
  logic signed [17:0] alpha_s;
  logic signed [37:0] prod_nxt;

  always_comb begin
    diff     = 20'(last_out_r[cmd.axis]) + 20'(x_r[cmd.axis]) - 20'(last_in_r[cmd.axis]);
    alpha_s  = $signed({1'b0, alpha});
    prod_nxt = diff * alpha_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
  end

  // round half up and saturate to 18 bits
  logic signed [37:0] rsum;
  logic signed [37:0] rsh;
  logic signed [ahpf_pkg::STATE_W-1:0] hp_sat;

  always_comb begin
    rsum = prod_r + 38'sd32768;
    rsh  = rsum >>> 16;
    if (rsh > 38'sd131071) begin
      hp_sat = 18'sd131071;
    end else if (rsh < -38'sd131072) begin
      hp_sat = -18'sd131072;
    end else begin
      hp_sat = 18'(rsh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      for (int i = 0; i < ahpf_pkg::NUM_AXES; i++) begin
        last_in_r[i]  <= '0;
        last_out_r[i] <= '0;
      end
    end else begin
      if (cmd.first) begin
        held_r <= CNT_W'(1);
        for (int i = 0; i < ahpf_pkg::NUM_AXES; i++) begin
          last_in_r[i]  <= x_r[i];
          last_out_r[i] <= 18'(x_r[i]);
        end
      end
      if (cmd.hp) begin
        last_in_r[cmd.axis]  <= x_r[cmd.axis];
        last_out_r[cmd.axis] <= hp_sat;
      end
      if (cmd.commit && (held_r < CNT_W'(HISTORY_DEPTH))) begin
        held_r <= held_r + CNT_W'(1);
      end
    end
  end

  // boost stage: the high-pass value sits in last_out after the hp step
  logic                                 boosted;
  logic signed [8:0]                    gain_s;
  logic signed [26:0]                   gp;
  logic signed [27:0]                   rsel;
  logic signed [ahpf_pkg::SAMPLE_W-1:0] r_sat;

  always_comb begin
    boosted = ahpf_pkg::WARM_W'(held_r) >= warm_r;
    gain_s  = $signed({1'b0, gain_r});
    gp      = gain_s * last_out_r[cmd.axis];
    if (boosted) begin
      rsel = 28'(gp) + 28'(x_r[cmd.axis]) - 28'(last_out_r[cmd.axis]);
    end else begin
      rsel = 28'(last_out_r[cmd.axis]);
    end
    if (rsel > 28'sd32767) begin
      r_sat = 16'sh7fff;
    end else if (rsel < -28'sd32768) begin
      r_sat = -16'sh8000;
    end else begin
      r_sat = 16'(rsel);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.raw) begin
      pass_r <= status.long_step;
      for (int i = 0; i < ahpf_pkg::NUM_AXES; i++) begin
        res_r[i] <= x_r[i];
      end
    end
    if (cmd.boost) begin
      res_r[cmd.axis] <= r_sat;
    end
  end

  logic [ahpf_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                            out_user_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {res_r[2], res_r[1], res_r[0]};
      out_user_r <= pass_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(HISTORY_DEPTH))
    else $error("held sample count above history depth");

endmodule

`default_nettype wire

[rtl/core/ahpf_ctrl.sv]
`default_nettype none

module ahpf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire ahpf_pkg::status_t status,
  output ahpf_pkg::cmd_t         cmd
);

  ahpf_pkg::state_t                  state_r, state_nxt;
  logic [ahpf_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ahpf_pkg::AXIS_W-1:0]       axis_r, axis_nxt;
  logic                              out_tvalid_r, out_tvalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ahpf_pkg::ST_IDLE;
      cnt_r        <= '0;
      axis_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      axis_r       <= axis_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    in_tready = 1'b0;

    case (state_r)
      ahpf_pkg::ST_IDLE: begin
        // nothing is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ahpf_pkg::ST_DECIDE;
        end
      end
      ahpf_pkg::ST_DECIDE: begin
        cmd.raw = 1'b1;
        if (status.long_step) begin
          state_nxt = ahpf_pkg::ST_FIN;
        end else if (status.first) begin
          cmd.first = 1'b1;
          state_nxt = ahpf_pkg::ST_FIN;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ahpf_pkg::ST_DIV;
        end
      end
      ahpf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ahpf_pkg::DIV_CNT_W'(ahpf_pkg::DIV_STEPS - 1)) begin
          axis_nxt  = '0;
          state_nxt = ahpf_pkg::ST_MUL;
        end
      end
      ahpf_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ahpf_pkg::ST_HP;
      end
      ahpf_pkg::ST_HP: begin
        cmd.hp    = 1'b1;
        state_nxt = ahpf_pkg::ST_BOOST;
      end
      ahpf_pkg::ST_BOOST: begin
        cmd.boost = 1'b1;
        if (axis_r == ahpf_pkg::AXIS_LAST) begin
          cmd.commit = 1'b1;
          state_nxt  = ahpf_pkg::ST_FIN;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ahpf_pkg::ST_MUL;
        end
      end
      ahpf_pkg::ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ahpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ahpf_pkg::ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  assign out_tvalid = out_tvalid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ahpf_pkg::ST_DECIDE)
    else $error("accepted transaction not decoded next cycle");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ahpf_pkg::ST_FIN))
    else $error("result raised outside finish state");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ahpf_pkg::ST_MUL || state_r == ahpf_pkg::ST_HP ||
     state_r == ahpf_pkg::ST_BOOST) |-> axis_r <= ahpf_pkg::AXIS_LAST)
    else $error("axis counter out of range");

endmodule

`default_nettype wire

[dv/ahpf_checker.sv]
`timescale 1ns / 1ps

module ahpf_checker
  import ahpf_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);

  // the core holds at most one result plus one sample in flight
  localparam int EXP_DEPTH = 4;

  typedef struct packed {
    logic [NUM_AXES-1:0][SAMPLE_W-1:0] axis;
    logic                              passed;
  } filtered_t;

  // register copies
  logic [RC_W-1:0]   rc_reg;
  logic [GAIN_W-1:0] gain_reg;
  logic [WARM_W-1:0] warm_reg;

  // filter history
  logic signed [SAMPLE_W-1:0] prev_in  [NUM_AXES];
  logic signed [STATE_W-1:0]  prev_out [NUM_AXES];
  int unsigned                held;

  // expected results in arrival order
  filtered_t exp_mem [EXP_DEPTH];
  int        exp_wr;
  int        exp_rd;
  int        exp_cnt;
  filtered_t want;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one accepted sample in, one expected result out, history updated
  function automatic filtered_t filter_accel(input logic [IN_DATA_W-1:0] d);
    filtered_t                  r;
    logic [DT_W-1:0]            dt;
    logic signed [SAMPLE_W-1:0] x;
    longint                     den, alpha, diff, hp, v;
    bit                         boosted;
    dt = d[DT_W-1:0];
    r.passed = 1'b0;
    if (dt > MAX_STEP_US || held == 0) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        x = d[DT_W + a*SAMPLE_W +: SAMPLE_W];
        r.axis[a] = x;
        if (dt <= MAX_STEP_US) begin
          prev_in[a]  = x;
          prev_out[a] = x;
        end
      end
      if (dt > MAX_STEP_US) r.passed = 1'b1;
      else held = 1;
      return r;
    end
    den = longint'(rc_reg) + longint'(dt);
    alpha = (den == 0) ? 65536 : ((longint'(rc_reg) << 16) / den);
    boosted = (held >= warm_reg);
    for (int a = 0; a < NUM_AXES; a++) begin
      x = d[DT_W + a*SAMPLE_W +: SAMPLE_W];
      diff = longint'(prev_out[a]) + longint'(x) - longint'(prev_in[a]);
      // round to nearest, ties up
      hp = clamp((diff * alpha + 32768) >>> 16, -131072, 131071);
      prev_out[a] = hp[STATE_W-1:0];
      prev_in[a]  = x;
      if (boosted) v = longint'(gain_reg) * hp + longint'(x) - hp;
      else v = hp;
      v = clamp(v, -32768, 32767);
      r.axis[a] = v[SAMPLE_W-1:0];
    end
    if (held < HISTORY_DEPTH) held++;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rc_reg   = RC_RESET;
      gain_reg = GAIN_RESET;
      warm_reg = WARM_RESET;
      for (int a = 0; a < NUM_AXES; a++) begin
        prev_in[a]  = '0;
        prev_out[a] = '0;
      end
      held    = 0;
      exp_wr  = 0;
      exp_rd  = 0;
      exp_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RC_US:        rc_reg   = cfg_wdata[RC_W-1:0];
          REG_BOOST_GAIN:   gain_reg = cfg_wdata[GAIN_W-1:0];
          REG_WARMUP_COUNT: warm_reg = cfg_wdata[WARM_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting so a result never matches its own sample
      if (out_tvalid && out_tready) begin
        if (exp_cnt == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual data %h passed %b",
                   $time, out_tdata, out_tuser);
        end else begin
          want    = exp_mem[exp_rd];
          exp_rd  = (exp_rd + 1) % EXP_DEPTH;
          exp_cnt = exp_cnt - 1;
          for (int a = 0; a < NUM_AXES; a++) begin
            if (out_tdata[a*SAMPLE_W +: SAMPLE_W] !== want.axis[a]) begin
              fail_count++;
              $display("%0t: axis %0d expected %0d actual %0d", $time, a,
                       $signed(want.axis[a]), $signed(out_tdata[a*SAMPLE_W +: SAMPLE_W]));
            end
          end
          if (out_tuser !== want.passed) begin
            fail_count++;
            $display("%0t: passed_through expected %b actual %b",
                     $time, want.passed, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (exp_cnt == EXP_DEPTH) begin
          fail_count++;
          $display("%0t: too many samples in flight, expected at most %0d, actual %0d",
                   $time, EXP_DEPTH, exp_cnt + 1);
        end else begin
          exp_mem[exp_wr] = filter_accel(in_tdata);
          exp_wr  = (exp_wr + 1) % EXP_DEPTH;
          exp_cnt = exp_cnt + 1;
        end
      end
    end
    pending_count = exp_cnt;
  end

endmodule

[dv/tb_accel_highpass_filter_core.sv]
`timescale 1ns / 1ps

module tb_accel_highpass_filter_core;
  import ahpf_pkg::*;

  localparam int unsigned DEPTH        = 128;
  // margin to wait after the last result has come back
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned SEGMENTS     = 6;
  localparam int unsigned SEG_ITEMS    = 325;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int fail_count;
  int pending_count;

  // idle chance per cycle, in percent, on each side
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 55;

  // last random sample per axis, used to make slowly moving signals
  logic [SAMPLE_W-1:0] last_accel [NUM_AXES];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  accel_highpass_filter_core #(
    .HISTORY_DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ahpf_checker #(
    .HISTORY_DEPTH(DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // receiver back-pressure, one decision per cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one input transaction; entered and left at a falling edge
  task automatic send_accel(input logic [DT_W-1:0] dt, input logic [SAMPLE_W-1:0] x,
                            input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x, dt};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop sending and wait until every result has come back and the core is quiet
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // written only while the core is idle
  task automatic set_config(input logic [RC_W-1:0] rc, input logic [GAIN_W-1:0] gain,
                            input logic [WARM_W-1:0] warm);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_RC_US;
    cfg_wdata <= rc;
    @(negedge clk);
    cfg_index <= REG_BOOST_GAIN;
    cfg_wdata <= gain;
    @(negedge clk);
    cfg_index <= REG_WARMUP_COUNT;
    cfg_wdata <= warm;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly small steps around the last value, some full-range noise and rails
  function automatic logic [SAMPLE_W-1:0] pick_accel(input logic [SAMPLE_W-1:0] prev);
    int unsigned         r;
    logic [31:0]         raw;
    logic [SAMPLE_W-1:0] v;
    r   = $urandom_range(99);
    raw = $urandom;
    if (r < 45) begin
      v = prev + 16'(raw[8:0]) - 16'd256;
    end else if (r < 80) begin
      v = raw[SAMPLE_W-1:0];
    end else begin
      case (raw[1:0])
        2'd0:    v = 16'h7fff;
        2'd1:    v = 16'h8000;
        2'd2:    v = 16'h0000;
        default: v = 16'hffff;
      endcase
    end
    return v;
  endfunction

  // short steps dominate; long steps and the one-second boundary now and then
  function automatic logic [DT_W-1:0] pick_dt;
    int unsigned     r;
    logic [DT_W-1:0] dt;
    r = $urandom_range(99);
    if (r < 40) dt = DT_W'($urandom_range(2000));
    else if (r < 75) dt = DT_W'($urandom_range(MAX_STEP_US));
    else if (r < 90) dt = DT_W'($urandom_range(24'hffffff, MAX_STEP_US + 1));
    else begin
      case ($urandom_range(3))
        0:       dt = '0;
        1:       dt = MAX_STEP_US;
        2:       dt = MAX_STEP_US + 24'd1;
        default: dt = 24'hffffff;
      endcase
    end
    return dt;
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] ax [NUM_AXES];

    for (int a = 0; a < NUM_AXES; a++) last_accel[a] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part, reset configuration ---
    // long step while nothing is held yet: raw, history untouched
    send_accel(24'hffffff, 16'h7fff, 16'h8000, 16'h0001);
    // first sample seeds the filter
    send_accel(24'd0, 16'h8000, 16'h7fff, 16'h0000);
    // exactly one second is still filtered, one more microsecond is not
    send_accel(MAX_STEP_US, 16'h7fff, 16'h8000, 16'h1234);
    send_accel(MAX_STEP_US + 24'd1, 16'hffff, 16'hffff, 16'hffff);
    send_accel(24'd0, 16'h0000, 16'h0000, 16'h0000);
    send_accel(24'd1, 16'h7fff, 16'h7fff, 16'h7fff);
    send_accel(24'd500, 16'h8000, 16'h8000, 16'h8000);

    // zero time constant: alpha one at zero step, zero otherwise; boost at once
    set_config('0, 8'd255, 8'd0);
    send_accel(24'd0, 16'h7fff, 16'h8000, 16'h0001);
    send_accel(24'd1, 16'h5a5a, 16'ha5a5, 16'h00ff);
    send_accel(24'd0, 16'h0000, 16'h0000, 16'h0000);
    send_accel(24'd0, 16'h8000, 16'h7fff, 16'hff00);

    // largest time constant, no gain, warmup beyond the history depth
    set_config(24'hffffff, 8'd0, 8'd255);
    send_accel(MAX_STEP_US, 16'h7fff, 16'h7fff, 16'h8000);
    send_accel(24'd3, 16'h8000, 16'h8000, 16'h7fff);
    send_accel(24'd0, 16'h1111, 16'heeee, 16'h0000);

    // smallest legal time constant, full gain
    set_config(24'd1, 8'd255, 8'd1);
    send_accel(24'd0, 16'h7fff, 16'h8000, 16'h0000);
    send_accel(24'd1, 16'h8000, 16'h7fff, 16'h0002);
    send_accel(24'd2, 16'h0100, 16'hff00, 16'h7fff);
    send_accel(24'hffffff, 16'h4321, 16'h8765, 16'h0000);

    // --- random part, several settings, three idling modes ---
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: set_config(RC_W'($urandom_range(5000, 1)), GAIN_W'($urandom_range(255)),
                      WARM_W'($urandom_range(255)));
        1: set_config(24'hffffff, 8'd0, 8'd0);
        2: set_config(24'd1, 8'd255, 8'd255);
        3: set_config(RC_W'($urandom_range(24'hffffff, 1)), 8'd1, 8'd128);
        4: set_config(RC_W'($urandom_range(100000, 1000)), GAIN_W'($urandom_range(255)),
                      8'd127);
        default: set_config(RC_RESET, GAIN_RESET, WARM_RESET);
      endcase
      case (seg / 2)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          ax[a] = pick_accel(last_accel[a]);
          last_accel[a] = ax[a];
        end
        send_accel(pick_dt(), ax[0], ax[1], ax[2]);
      end
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
